### hw/rtl/cswp_pkg.sv
// Shared constants, types and the sequencer program of the waypoint stepper.
package cswp_pkg;

  localparam int POS_W    = 32;
  localparam int DW       = 36;
  localparam int SPD_W    = 12;
  localparam int KIND_W   = 2;
  localparam int SPEEDU_W = 15;
  localparam int STEP_W   = 18;
  localparam int NUM_W    = 25;
  localparam int RECIP_K  = 25;
  localparam int RECIP_W  = 19;
  localparam int RECIP_M  = (1 << RECIP_K) / 100;
  localparam int GAIN_W   = 16;
  localparam int GAIN_INV = 39797;
  localparam int CFG_AW   = 5;
  localparam int REG_IDX_W = 3;
  localparam int PC_W     = 3;
  localparam int UC_DEPTH = 8;

  localparam logic [KIND_W-1:0] KIND_MISSILE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AIRCRAFT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd2;

  localparam logic [SPD_W-1:0] MIS_REQ_LO = 12'd256;
  localparam logic [SPD_W-1:0] MIS_REQ_HI = 12'd2560;
  localparam logic [SPD_W-1:0] AIR_REQ_LO = 12'd25;
  localparam logic [SPD_W-1:0] AIR_REQ_HI = 12'd256;

  localparam logic [SPEEDU_W-1:0] SPEED_AIR_MIN = 15'd256;
  localparam logic [SPEEDU_W-1:0] SPEED_MACH1   = 15'd2560;
  localparam logic [SPEEDU_W-1:0] SPEED_MACH10  = 15'd25600;
  localparam logic [SPEEDU_W-1:0] SPEED_SCALE   = 15'd10;

  localparam logic [REG_IDX_W-1:0] REG_START_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KIND     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPEED    = 3'd5;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_WAIT    = 3'd0,
    OP_DIFF    = 3'd1,
    OP_VEC     = 3'd2,
    OP_ROTINIT = 3'd3,
    OP_ROT     = 3'd4,
    OP_UPD     = 3'd5,
    OP_LOAD    = 3'd6,
    OP_EMIT    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT    = 3'd0,
    C_GOTO    = 3'd1,
    C_ACCEPT  = 3'd2,
    C_LOOP    = 3'd3,
    C_OUTFREE = 3'd4
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  localparam pc_t PC_WAIT = 3'd0;
  localparam pc_t PC_NONE = 3'd0;
  localparam pc_t PC_LOAD = 3'd6;
  localparam pc_t PC_EMIT = 3'd7;

  localparam ctrl_word_t UCODE [UC_DEPTH] = '{
    '{OP_WAIT,    C_ACCEPT,  PC_LOAD},
    '{OP_DIFF,    C_NEXT,    PC_NONE},
    '{OP_VEC,     C_LOOP,    PC_NONE},
    '{OP_ROTINIT, C_NEXT,    PC_NONE},
    '{OP_ROT,     C_LOOP,    PC_NONE},
    '{OP_UPD,     C_GOTO,    PC_EMIT},
    '{OP_LOAD,    C_NEXT,    PC_NONE},
    '{OP_EMIT,    C_OUTFREE, PC_WAIT}
  };

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [DW:0] v);
    if ((&v[DW:POS_W-1]) || !(|v[DW:POS_W-1])) begin
      return v[POS_W-1:0];
    end else if (v[DW]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

endpackage

### hw/rtl/cswp_if.sv
// Stream interfaces for the stepper's item and result channels.
interface cswp_in_if;
  import cswp_pkg::*;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface cswp_out_if;
  import cswp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

### hw/rtl/cswp_step_len.sv
// Registered pipeline that turns threat kind and Mach request into step length.
module cswp_step_len import cswp_pkg::*; #(
  parameter int SOUND_SPEED = 340
) (
  input  logic              clk,
  input  logic [KIND_W-1:0] kind,
  input  logic [SPD_W-1:0]  req_speed,
  output logic [STEP_W-1:0] step_len,
  output logic [STEP_W-1:0] step_scaled
);

  logic [SPEEDU_W-1:0]        speed_r, speed_nxt;
  logic [NUM_W-1:0]           num_r, num_nxt;
  logic [NUM_W-1:0]           num_d_r;
  logic [STEP_W-1:0]          est_r, est_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [STEP_W-1:0]          scaled_r, scaled_nxt;
  logic [NUM_W+RECIP_W-1:0]   recip_prod;
  logic [NUM_W-1:0]           est_back;
  logic [NUM_W-1:0]           rem;
  logic [STEP_W+GAIN_W-1:0]   gain_prod;

  always_comb begin
    speed_nxt = '0;
    case (kind)
      KIND_MISSILE: begin
        if (req_speed <= MIS_REQ_LO) begin
          speed_nxt = SPEED_MACH1;
        end else if (req_speed > MIS_REQ_HI) begin
          speed_nxt = SPEED_MACH10;
        end else begin
          speed_nxt = SPEEDU_W'(req_speed) * SPEED_SCALE;
        end
      end
      KIND_AIRCRAFT: begin
        if (req_speed <= AIR_REQ_LO) begin
          speed_nxt = SPEED_AIR_MIN;
        end else if (req_speed > AIR_REQ_HI) begin
          speed_nxt = SPEED_MACH1;
        end else begin
          speed_nxt = SPEEDU_W'(req_speed) * SPEED_SCALE;
        end
      end
      default: speed_nxt = '0;
    endcase
  end

  assign num_nxt    = NUM_W'(32'(speed_r) * 32'(SOUND_SPEED) + 32'd50);
  assign recip_prod = (NUM_W+RECIP_W)'(num_r) * (NUM_W+RECIP_W)'(RECIP_M);
  assign est_nxt    = STEP_W'(recip_prod >> RECIP_K);
  assign est_back   = NUM_W'(est_r) * NUM_W'(100);
  assign rem        = num_d_r - est_back;
  assign step_nxt   = est_r + STEP_W'(rem >= NUM_W'(100));
  assign gain_prod  = (STEP_W+GAIN_W)'(step_r) * (STEP_W+GAIN_W)'(GAIN_INV);
  assign scaled_nxt = STEP_W'(gain_prod >> GAIN_W);

  always_ff @(posedge clk) begin
    speed_r  <= speed_nxt;
    num_r    <= num_nxt;
    num_d_r  <= num_r;
    est_r    <= est_nxt;
    step_r   <= step_nxt;
    scaled_r <= scaled_nxt;
  end

  assign step_len    = step_r;
  assign step_scaled = scaled_r;

endmodule

### hw/rtl/constant_speed_waypoint_stepper_top.sv
// Top level of the constant-speed waypoint stepper.
// The block steps a point towards a configured target once per input item.
// Input channel in_ch carries one bit, restart: 1 reloads the start position,
// 0 advances one 0.1 s tick at the clamped Mach speed towards the target.
// Each item yields exactly one result on out_ch: the new position (Q24.8).
// A small microcode sequencer drives one shared CORDIC datapath: a vectoring
// pass finds the direction, a rotation pass turns the step length onto it.
// An advance runs the difference, vectoring loop, rotation setup, rotation
// loop, update and emit steps, making two passes through the one CORDIC
// stage; a restart only reloads and emits. One item is in work at a time;
// a finished result waits in the output register while the next item is
// accepted. If the receiver stalls, a second result waits in the final step
// until the output register frees, and no further item is accepted meanwhile.
// Reset clears the position to the origin, the registers to their reset values
// and the output valid flag. Kind and speed act via cswp_step_len's registers.
// Register writes over the APB port must be made while the block idles.
module constant_speed_waypoint_stepper_top import cswp_pkg::*; #(
  parameter int SOUND_SPEED  = 340,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  cswp_in_if.sink           in_ch,
  cswp_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = $clog2(CORDIC_STEPS);

  logic [POS_W-1:0]  start_x_r, start_y_r, tgt_x_r, tgt_y_r;
  logic [KIND_W-1:0] kind_r;
  logic [SPD_W-1:0]  speed_r;
  logic              cfg_wr;

  logic [STEP_W-1:0] step_len, step_scaled;

  pc_t                     pc_r, pc_nxt;
  ctrl_word_t              cw;
  logic [IW-1:0]           i_r, i_nxt;
  logic                    flip_r, flip_nxt;
  logic                    zero_r, zero_nxt;
  logic [CORDIC_STEPS-1:0] signs_r, signs_nxt;
  logic signed [DW-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic [POS_W-1:0]        cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]        out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  logic                    in_acc, out_free, last_i;
  logic signed [POS_W:0]   dx, dy;
  logic signed [DW-1:0]    dx_e, dy_e, xs, ys, mx, my;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      tgt_x_r   <= '0;
      tgt_y_r   <= '0;
      kind_r    <= KIND_NONE;
      speed_r   <= '0;
    end else if (cfg_wr) begin
      case (paddr[CFG_AW-1:2])
        REG_START_X:  start_x_r <= pwdata;
        REG_START_Y:  start_y_r <= pwdata;
        REG_TARGET_X: tgt_x_r   <= pwdata;
        REG_TARGET_Y: tgt_y_r   <= pwdata;
        REG_KIND:     kind_r    <= pwdata[KIND_W-1:0];
        REG_SPEED:    speed_r   <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1:2])
      REG_START_X:  prdata = start_x_r;
      REG_START_Y:  prdata = start_y_r;
      REG_TARGET_X: prdata = tgt_x_r;
      REG_TARGET_Y: prdata = tgt_y_r;
      REG_KIND:     prdata = 32'(kind_r);
      REG_SPEED:    prdata = 32'(speed_r);
      default:      prdata = '0;
    endcase
  end

  cswp_step_len #(.SOUND_SPEED(SOUND_SPEED)) u_step_len (
    .clk         (clk),
    .kind        (kind_r),
    .req_speed   (speed_r),
    .step_len    (step_len),
    .step_scaled (step_scaled)
  );

  assign cw           = UCODE[pc_r];
  assign in_ch.ready  = (cw.op == OP_WAIT);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign last_i       = (i_r == IW'(CORDIC_STEPS - 1));

  always_comb begin
    case (cw.cond)
      C_NEXT:    pc_nxt = pc_r + 1'b1;
      C_GOTO:    pc_nxt = cw.target;
      C_ACCEPT:  pc_nxt = !in_acc ? pc_r : (in_ch.restart ? cw.target : pc_r + 1'b1);
      C_LOOP:    pc_nxt = last_i ? pc_r + 1'b1 : pc_r;
      C_OUTFREE: pc_nxt = out_free ? cw.target : pc_r;
      default:   pc_nxt = PC_WAIT;
    endcase
  end

  assign dx   = $signed({tgt_x_r[POS_W-1], tgt_x_r}) - $signed({cur_x_r[POS_W-1], cur_x_r});
  assign dy   = $signed({tgt_y_r[POS_W-1], tgt_y_r}) - $signed({cur_y_r[POS_W-1], cur_y_r});
  assign dx_e = DW'(dx);
  assign dy_e = DW'(dy);
  assign xs   = x_r >>> i_r;
  assign ys   = y_r >>> i_r;

  always_comb begin
    if (zero_r) begin
      mx = $signed(DW'(step_len));
      my = '0;
    end else if (flip_r) begin
      mx = -x_r;
      my = -y_r;
    end else begin
      mx = x_r;
      my = y_r;
    end
  end

  always_comb begin
    i_nxt         = i_r;
    flip_nxt      = flip_r;
    zero_nxt      = zero_r;
    signs_nxt     = signs_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (cw.op)
      OP_DIFF: begin
        flip_nxt = dx[POS_W];
        zero_nxt = (dx == '0) && (dy == '0);
        x_nxt    = dx[POS_W] ? -dx_e : dx_e;
        y_nxt    = dx[POS_W] ? -dy_e : dy_e;
        i_nxt    = '0;
      end
      OP_VEC: begin
        if (!y_r[DW-1]) begin
          x_nxt          = x_r + ys;
          y_nxt          = y_r - xs;
          signs_nxt[i_r] = 1'b1;
        end else begin
          x_nxt          = x_r - ys;
          y_nxt          = y_r + xs;
          signs_nxt[i_r] = 1'b0;
        end
        i_nxt = i_r + 1'b1;
      end
      OP_ROTINIT: begin
        x_nxt = $signed(DW'(step_scaled));
        y_nxt = '0;
        i_nxt = '0;
      end
      OP_ROT: begin
        if (signs_r[i_r]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
        end
        i_nxt = i_r + 1'b1;
      end
      OP_UPD: begin
        cur_x_nxt = sat_pos((DW+1)'($signed(cur_x_r)) + (DW+1)'(mx));
        cur_y_nxt = sat_pos((DW+1)'($signed(cur_y_r)) + (DW+1)'(my));
      end
      OP_LOAD: begin
        cur_x_nxt = start_x_r;
        cur_y_nxt = start_y_r;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_x_nxt     = cur_x_r;
          out_y_nxt     = cur_y_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_WAIT;
      out_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    flip_r  <= flip_nxt;
    zero_r  <= zero_nxt;
    signs_r <= signs_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = out_x_r;
  assign out_ch.pos_y = out_y_r;

endmodule

### hw/rtl/cswp_checker.sv
// Port-level assertions for the stepper top level, attached by bind.
module cswp_props import cswp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] out_pos_x,
  input logic [POS_W-1:0] out_pos_y
);

  logic [1:0] pending_r, pending_nxt;

  assign pending_nxt = pending_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_pos_y))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result offered without an item");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("too many items outstanding");

endmodule

bind constant_speed_waypoint_stepper_top cswp_props u_cswp_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pos_x (out_ch.pos_x),
  .out_pos_y (out_ch.pos_y)
);

### sim/cswp_checker.sv
// Checker for the waypoint stepper: tracks its settings, predicts each position and compares.
module cswp_checker import cswp_pkg::*; #(
  parameter int SOUND_SPEED  = 340,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  cswp_in_if                in_ch,
  cswp_out_if               out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } point_t;

  point_t expected_pos[$];

  logic signed [POS_W-1:0] start_x, start_y, target_x, target_y;
  logic signed [POS_W-1:0] cur_x, cur_y;
  logic [KIND_W-1:0]       kind;
  logic [SPD_W-1:0]        req_speed;

  function automatic longint mach_units(input logic [KIND_W-1:0] k,
                                        input logic [SPD_W-1:0] r);
    longint rq;
    rq = r;
    if (k == KIND_MISSILE) begin
      if (rq <= MIS_REQ_LO) return SPEED_MACH1;
      if (rq > MIS_REQ_HI) return SPEED_MACH10;
      return rq * SPEED_SCALE;
    end
    if (k == KIND_AIRCRAFT) begin
      if (rq * SPEED_SCALE <= SPEED_AIR_MIN) return SPEED_AIR_MIN;
      if (rq > AIR_REQ_HI) return SPEED_MACH1;
      return rq * SPEED_SCALE;
    end
    return 0;
  endfunction

  function automatic logic signed [POS_W-1:0] clip_pos(input longint v);
    if (v > POS_MAX) return POS_MAX[POS_W-1:0];
    if (v < POS_MIN) return POS_MIN[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

  // One tick: vectoring pass records the turn directions, rotation pass replays them.
  function automatic void advance_point();
    longint step, dx, dy, vx, vy, u, w, xs, ys, us, ws, mx, my;
    logic [63:0] dir_bits;
    bit flip;
    step = (mach_units(kind, req_speed) * SOUND_SPEED + 50) / 100;
    dx = longint'(target_x) - longint'(cur_x);
    dy = longint'(target_y) - longint'(cur_y);
    if (dx == 0 && dy == 0) begin
      mx = step;
      my = 0;
    end else begin
      flip = dx < 0;
      vx = flip ? -dx : dx;
      vy = flip ? -dy : dy;
      dir_bits = '0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = vx >>> i;
        ys = vy >>> i;
        if (vy >= 0) begin
          vx = vx + ys;
          vy = vy - xs;
          dir_bits[i] = 1'b1;
        end else begin
          vx = vx - ys;
          vy = vy + xs;
        end
      end
      u = (step * GAIN_INV) >>> 16;
      w = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        us = u >>> i;
        ws = w >>> i;
        if (dir_bits[i]) begin
          u = u - ws;
          w = w + us;
        end else begin
          u = u + ws;
          w = w - us;
        end
      end
      mx = flip ? -u : u;
      my = flip ? -w : w;
    end
    cur_x = clip_pos(longint'(cur_x) + mx);
    cur_y = clip_pos(longint'(cur_y) + my);
  endfunction

  always @(posedge clk) begin
    point_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      start_x = '0;
      start_y = '0;
      target_x = '0;
      target_y = '0;
      kind = KIND_NONE;
      req_speed = '0;
      cur_x = '0;
      cur_y = '0;
      expected_pos.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_AW-1:2])
          REG_START_X:  start_x = pwdata;
          REG_START_Y:  start_y = pwdata;
          REG_TARGET_X: target_x = pwdata;
          REG_TARGET_Y: target_y = pwdata;
          REG_KIND:     kind = pwdata[KIND_W-1:0];
          REG_SPEED:    req_speed = pwdata[SPD_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pos.size() == 0) begin
          $display("%0t: unexpected position (%0d, %0d)", $time,
                   $signed(out_ch.pos_x), $signed(out_ch.pos_y));
          bad++;
        end else begin
          want = expected_pos.pop_front();
          if (out_ch.pos_x !== want.x) begin
            $display("%0t: pos_x expected %0d got %0d", $time,
                     $signed(want.x), $signed(out_ch.pos_x));
            bad++;
          end
          if (out_ch.pos_y !== want.y) begin
            $display("%0t: pos_y expected %0d got %0d", $time,
                     $signed(want.y), $signed(out_ch.pos_y));
            bad++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.restart) begin
          cur_x = start_x;
          cur_y = start_y;
        end else begin
          advance_point();
        end
        want.x = cur_x;
        want.y = cur_y;
        expected_pos.push_back(want);
      end
      errors <= errors + bad;
      pending <= expected_pos.size();
    end
  end

endmodule

### sim/tb_constant_speed_waypoint_stepper_top.sv
// Testbench top for the waypoint stepper: clock, reset, settings, items and verdict.
module tb_constant_speed_waypoint_stepper_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cswp_pkg::*;

  localparam int SOUND_SPEED  = 340;
  localparam int CORDIC_STEPS = 16;

  typedef struct {
    logic [31:0]       sx;
    logic [31:0]       sy;
    logic [31:0]       tx;
    logic [31:0]       ty;
    logic [KIND_W-1:0] kind;
    logic [SPD_W-1:0]  speed;
  } waypoint_cfg_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                errors;
  int                pending;
  int                sent = 0;
  bit                steady = 0;

  cswp_in_if  in_ch ();
  cswp_out_if out_ch ();

  constant_speed_waypoint_stepper_top #(
    .SOUND_SPEED (SOUND_SPEED),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  cswp_checker #(
    .SOUND_SPEED (SOUND_SPEED),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .pready (pready),
    .paddr  (paddr),
    .pwdata (pwdata),
    .errors (errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_constant_speed_waypoint_stepper_top NOT OK");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($urandom_range(131071)) - 32'd65536;
      2: return 32'h7FFF_FFFF - 32'($urandom_range(100000));
      3: return 32'h8000_0000 + 32'($urandom_range(100000));
      default: return '0;
    endcase
  endfunction

  function automatic waypoint_cfg_t random_cfg();
    waypoint_cfg_t c;
    logic [SPD_W-1:0] edges [8] = '{0, 25, 26, 256, 257, 2560, 2561, 4095};
    int r;
    r = $urandom_range(99);
    if (r < 40) c.kind = KIND_MISSILE;
    else if (r < 80) c.kind = KIND_AIRCRAFT;
    else c.kind = KIND_W'($urandom_range(2, 3));
    if ($urandom_range(99) < 30) c.speed = edges[$urandom_range(7)];
    else c.speed = SPD_W'($urandom_range(4095));
    c.tx = pick_coord();
    c.ty = pick_coord();
    if ($urandom_range(99) < 60) begin
      c.sx = c.tx + 32'($urandom_range(200000)) - 32'd100000;
      c.sy = c.ty + 32'($urandom_range(200000)) - 32'd100000;
      if ($urandom_range(99) < 15) c.sx = c.tx;
      else if ($urandom_range(99) < 15) c.sy = c.ty;
    end else begin
      c.sx = pick_coord();
      c.sy = pick_coord();
    end
    return c;
  endfunction

  task automatic apply_cfg(input waypoint_cfg_t c);
    logic [31:0] vals [REG_SPEED + 1];
    vals[REG_START_X]  = c.sx;
    vals[REG_START_Y]  = c.sy;
    vals[REG_TARGET_X] = c.tx;
    vals[REG_TARGET_Y] = c.ty;
    vals[REG_KIND]     = 32'(c.kind);
    vals[REG_SPEED]    = 32'(c.speed);
    for (int r = REG_START_X; r <= REG_SPEED; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CFG_AW'(r * 4);
      pwdata  <= vals[r];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(input bit rs);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.restart <= rs;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic play(input int n, input logic [63:0] restarts);
    for (int i = 0; i < n; i++) send_item(restarts[i]);
  endtask

  task automatic drain();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Drains, applies the new settings and waits for them to reach the datapath before sending items.
  task automatic phase(input waypoint_cfg_t c, input int n, input logic [63:0] restarts);
    drain();
    apply_cfg(c);
    repeat (8) @(posedge clk);
    play(n, restarts);
  endtask

  initial begin
    int n;
    bit held;
    held = 0;
    forever begin
      if (!held && sent >= 260) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        case ($urandom_range(9))
          0, 1, 2: begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(10, 60)) @(posedge clk);
          end
          3: begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(20, 40)) @(posedge clk);
          end
          default: begin
            n = $urandom_range(5, 30);
            repeat (n) begin
              out_ch.ready <= ($urandom_range(99) < 70);
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  initial begin
    waypoint_cfg_t c;
    logic [63:0] restarts;
    int n;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings after reset: an unused kind, so the point stays at the origin.
    play(3, 64'b100);
    c = '{32'h0, 32'h0, 32'h0, 32'h0, KIND_MISSILE, 12'd0};
    phase(c, 4, 64'b0001);
    c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, KIND_MISSILE, 12'd4095};
    phase(c, 3, 64'b001);
    c = '{32'h8000_0005, 32'h7FFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF, KIND_AIRCRAFT, 12'd0};
    phase(c, 3, 64'b001);
    c = '{32'h7FFF_FF00, 32'h7FFF_FF00, 32'h8000_0000, 32'h8000_0000, KIND_AIRCRAFT, 12'd4095};
    phase(c, 4, 64'b0001);
    c = '{32'h0, 32'h0, 32'h0, 32'h0010_0000, KIND_AIRCRAFT, 12'd26};
    phase(c, 3, 64'b001);
    c = '{32'h0, 32'h0, 32'hFFFF_F000, 32'h0, KIND_MISSILE, 12'd2560};
    phase(c, 3, 64'b001);

    while (sent < 650) begin
      c = random_cfg();
      n = $urandom_range(20, 50);
      restarts = '0;
      for (int i = 0; i < n; i++) restarts[i] = ($urandom_range(99) < 8);
      restarts[0] = ($urandom_range(99) < 80);
      steady = ($urandom_range(99) < 25);
      phase(c, n, restarts);
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_constant_speed_waypoint_stepper_top OK");
    end else begin
      $display("tb_constant_speed_waypoint_stepper_top NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/cswp_pkg.sv
hw/rtl/cswp_if.sv
hw/rtl/cswp_step_len.sv
hw/rtl/constant_speed_waypoint_stepper_top.sv
hw/rtl/cswp_checker.sv
sim/cswp_checker.sv
sim/tb_constant_speed_waypoint_stepper_top.sv
